[rtl/core/config_packet_crc_fixer_unit_macros.svh]
// Assertion macros for the configuration packet CRC fixer.
// Included by the top level; no other dependencies.
`ifndef CONFIG_PACKET_CRC_FIXER_UNIT_MACROS_SVH
`define CONFIG_PACKET_CRC_FIXER_UNIT_MACROS_SVH

// Antecedent in a cycle implies consequent in the same cycle
`define CPCF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Antecedent in a cycle implies consequent in the next cycle
`define CPCF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/cpcf_pkg.sv]
// Shared types, codes and CRC32C network for the configuration packet CRC fixer.
// No dependencies.
`timescale 1ns / 1ps

package cpcf_pkg;

  // Stream constants
  localparam logic [31:0] SYNC_WORD   = 32'haa995566;
  localparam logic [31:0] WIDTH_WORD1 = 32'h000000bb;
  localparam logic [31:0] WIDTH_WORD2 = 32'h11220044;
  localparam logic [31:0] PAD_WORD    = 32'hffffffff;
  localparam logic [31:0] RCRC_CMD    = 32'h00000007;
  localparam logic [31:0] CRC_POLY    = 32'h82f63b78;

  // Packet types and opcodes
  localparam logic [2:0] PT_TYPE1 = 3'd1;
  localparam logic [2:0] PT_TYPE2 = 3'd2;
  localparam logic [1:0] OP_NOP   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  // Register addresses with special handling
  localparam logic [4:0] REG_CRC    = 5'h00;
  localparam logic [4:0] REG_CMD    = 5'h04;
  localparam logic [4:0] REG_IDCODE = 5'h0c;

  // Result word kinds
  localparam logic [1:0] KIND_PRE  = 2'd0;
  localparam logic [1:0] KIND_SYNC = 2'd1;
  localparam logic [1:0] KIND_HDR  = 2'd2;
  localparam logic [1:0] KIND_DATA = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_PRE   = 3'd1;
  localparam logic [2:0] ST_BAD_WIDTH = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_T1_COUNT  = 3'd4;
  localparam logic [2:0] ST_NOP_COUNT = 3'd5;
  localparam logic [2:0] ST_BAD_OP    = 3'd6;

  // Configuration register indexes
  localparam logic CFG_IDX_ENABLE = 1'b0;
  localparam logic CFG_IDX_IDCODE = 1'b1;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Output payload layout
  localparam int OUT_TDATA_W = 72;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_WIDTH  = 4'b0010,
    PH_SYNCED = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_t;

  // Pre-decoded input word
  typedef struct packed {
    logic [31:0] word;
    logic        is_sync;
    logic        is_pad;
    logic        is_w1;
    logic        is_w2;
    logic        is_rcrc;
    logic [2:0]  ptype;
    logic [1:0]  hdr_op;
    logic [4:0]  hdr_reg;
    logic        cnt_nz;
    logic        cnt_gt1;
  } item_t;

  // Queue status toward the top level
  typedef struct packed {
    logic              full;
    logic              valid;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  // Back-end status toward the top level
  typedef struct packed {
    logic pop;
    logic stopped;
  } back_stat_t;

  typedef logic [31:0][31:0] crc_mask32_t;
  typedef logic [31:0][4:0]  crc_mask5_t;

  // Bit-serial CRC32C over 32 data bits then 5 address bits (elaboration only)
  function automatic logic [31:0] crc_raw(logic [31:0] c, logic [31:0] d, logic [4:0] r);
    logic [36:0] v;
    logic        fb;
    v = {r, d};
    for (int i = 0; i < 37; i++) begin
      fb = c[0] ^ v[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Column masks of the linear update: crc part
  function automatic crc_mask32_t build_cmask();
    crc_mask32_t m;
    logic [31:0] col;
    for (int j = 0; j < 32; j++) begin
      col = crc_raw(32'(1) << j, 32'd0, 5'd0);
      for (int i = 0; i < 32; i++) begin
        m[i][j] = col[i];
      end
    end
    return m;
  endfunction

  // Column masks: data part
  function automatic crc_mask32_t build_dmask();
    crc_mask32_t m;
    logic [31:0] col;
    for (int j = 0; j < 32; j++) begin
      col = crc_raw(32'd0, 32'(1) << j, 5'd0);
      for (int i = 0; i < 32; i++) begin
        m[i][j] = col[i];
      end
    end
    return m;
  endfunction

  // Column masks: register address part
  function automatic crc_mask5_t build_rmask();
    crc_mask5_t  m;
    logic [31:0] col;
    for (int j = 0; j < 5; j++) begin
      col = crc_raw(32'd0, 32'd0, 5'(1) << j);
      for (int i = 0; i < 32; i++) begin
        m[i][j] = col[i];
      end
    end
    return m;
  endfunction

  localparam crc_mask32_t CRC_CMASK = build_cmask();
  localparam crc_mask32_t CRC_DMASK = build_dmask();
  localparam crc_mask5_t  CRC_RMASK = build_rmask();

  // One 37-bit CRC32C update as a flat XOR network, one parity per output bit
  function automatic logic [31:0] crc_step(logic [31:0] c, logic [31:0] d, logic [4:0] r);
    logic [31:0] n;
    for (int i = 0; i < 32; i++) begin
      n[i] = (^(c & CRC_CMASK[i])) ^ (^(d & CRC_DMASK[i])) ^ (^(r & CRC_RMASK[i]));
    end
    return n;
  endfunction

  // Registers left out of the CRC
  function automatic logic reg_skipped(logic [4:0] r);
    logic s;
    case (r)
      5'h00, 5'h0f, 5'h12, 5'h14, 5'h15, 5'h16: s = 1'b1;
      default: s = 1'b0;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/cpcf_front.sv]
// Front end: accepts stream words and pre-decodes them for the back end.
// Depends on cpcf_pkg.
`timescale 1ns / 1ps

module cpcf_front import cpcf_pkg::*; (
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] in_word
  input  logic        q_full,
  output logic        push,
  output item_t       push_item
);

  // Accept whenever the queue has room
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  // Compare against the fixed stream words and split header fields
  always_comb begin
    push_item.word    = in_tdata;
    push_item.is_sync = (in_tdata == SYNC_WORD);
    push_item.is_pad  = (in_tdata == PAD_WORD);
    push_item.is_w1   = (in_tdata == WIDTH_WORD1);
    push_item.is_w2   = (in_tdata == WIDTH_WORD2);
    push_item.is_rcrc = (in_tdata == RCRC_CMD);
    push_item.ptype   = in_tdata[31:29];
    push_item.hdr_op  = in_tdata[28:27];
    push_item.hdr_reg = in_tdata[17:13];
    push_item.cnt_nz  = (in_tdata[10:0] != 11'd0);
    push_item.cnt_gt1 = (in_tdata[10:1] != 10'd0);
  end

endmodule

[rtl/core/cpcf_queue.sv]
// Two-entry queue of pre-decoded words between front and back ends.
// Depends on cpcf_pkg.
`timescale 1ns / 1ps

module cpcf_queue import cpcf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head,
  output q_stat_t stat
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.valid = (count_r != '0);
  assign stat.count = count_r;

endmodule

[rtl/core/cpcf_back.sv]
// Back end: sync hunt, packet tracking, CRC32C update and word repair,
// with the output register. Depends on cpcf_pkg.
`timescale 1ns / 1ps

module cpcf_back import cpcf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  item_t                  head,
  input  logic                   idc_en,
  input  logic [31:0]            idc_val,
  output back_stat_t             stat,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] out_word, [34:32] status, [35] crc_replaced, [36] idcode_replaced,
  // [68:37] running_crc, [71:69] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser  // [1:0] word_kind
);

  phase_t      phase_r, phase_nxt;
  logic [26:0] left_r, left_nxt;
  logic [4:0]  treg_r, treg_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        clr_r, clr_nxt;
  logic [2:0]  err_r, err_nxt;

  logic        ovld_r, ovld_nxt;
  logic [31:0] oword_r, oword_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [2:0]  ostat_r, ostat_nxt;
  logic        ocrep_r, ocrep_nxt;
  logic        oidrep_r, oidrep_nxt;

  logic        pop;
  logic        clr_now;

  // Take the next word when the output register is free or draining
  assign pop = q_valid && (!ovld_r || out_tready);

  // Parser and CRC next state for the word at the queue head
  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    treg_nxt   = treg_r;
    op_nxt     = op_r;
    crc_nxt    = crc_r;
    clr_nxt    = clr_r;
    err_nxt    = err_r;
    oword_nxt  = head.word;
    okind_nxt  = KIND_PRE;
    ostat_nxt  = ST_OK;
    ocrep_nxt  = 1'b0;
    oidrep_nxt = 1'b0;
    clr_now    = clr_r;

    case (phase_r)
      PH_HUNT: begin
        if (head.is_sync) begin
          phase_nxt = PH_SYNCED;
          crc_nxt   = '0;
          clr_nxt   = 1'b0;
          left_nxt  = '0;
          okind_nxt = KIND_SYNC;
        end else if (head.is_w1) begin
          phase_nxt = PH_WIDTH;
        end else if (!head.is_pad) begin
          phase_nxt = PH_ERROR;
          err_nxt   = ST_BAD_PRE;
          ostat_nxt = ST_BAD_PRE;
        end
      end
      PH_WIDTH: begin
        if (head.is_w2) begin
          phase_nxt = PH_HUNT;
        end else begin
          phase_nxt = PH_ERROR;
          err_nxt   = ST_BAD_WIDTH;
          ostat_nxt = ST_BAD_WIDTH;
        end
      end
      PH_SYNCED: begin
        if (left_r == '0) begin
          // header word
          okind_nxt = KIND_HDR;
          if (head.ptype == PT_TYPE1) begin
            op_nxt   = head.hdr_op;
            treg_nxt = head.hdr_reg;
            if (head.cnt_gt1) begin
              phase_nxt = PH_ERROR;
              err_nxt   = ST_T1_COUNT;
              ostat_nxt = ST_T1_COUNT;
            end else if (head.hdr_op == OP_NOP && head.cnt_nz) begin
              phase_nxt = PH_ERROR;
              err_nxt   = ST_NOP_COUNT;
              ostat_nxt = ST_NOP_COUNT;
            end else if (head.hdr_op == OP_RSVD) begin
              phase_nxt = PH_ERROR;
              err_nxt   = ST_BAD_OP;
              ostat_nxt = ST_BAD_OP;
            end else begin
              left_nxt = {26'd0, head.cnt_nz};
            end
          end else if (head.ptype == PT_TYPE2) begin
            left_nxt = head.word[26:0];
          end else begin
            phase_nxt = PH_ERROR;
            err_nxt   = ST_BAD_TYPE;
            ostat_nxt = ST_BAD_TYPE;
          end
        end else begin
          // data word: register actions for writes
          okind_nxt = KIND_DATA;
          if (op_r == OP_WRITE) begin
            if (treg_r == REG_CRC) begin
              if (head.word != crc_r) begin
                oword_nxt = crc_r;
                ocrep_nxt = 1'b1;
              end
              clr_now = 1'b1;
            end else if (treg_r == REG_CMD) begin
              if (head.is_rcrc) begin
                clr_now = 1'b1;
              end
            end else if (treg_r == REG_IDCODE) begin
              if (idc_en) begin
                oword_nxt  = idc_val;
                oidrep_nxt = 1'b1;
              end
            end
          end
          // CRC update on the forwarded word
          if (clr_now) begin
            crc_nxt = '0;
            clr_nxt = 1'b0;
          end else if (!reg_skipped(treg_r)) begin
            crc_nxt = crc_step(crc_r, oword_nxt, treg_r);
          end
          left_nxt = left_r - 27'd1;
        end
      end
      PH_ERROR: begin
        ostat_nxt = err_r;
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase
  end

  // Output register valid
  assign ovld_nxt = pop || (ovld_r && !out_tready);

  // Control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      left_r  <= '0;
      treg_r  <= '0;
      op_r    <= '0;
      crc_r   <= '0;
      clr_r   <= 1'b0;
      err_r   <= ST_OK;
      ovld_r  <= 1'b0;
    end else begin
      ovld_r <= ovld_nxt;
      if (pop) begin
        phase_r <= phase_nxt;
        left_r  <= left_nxt;
        treg_r  <= treg_nxt;
        op_r    <= op_nxt;
        crc_r   <= crc_nxt;
        clr_r   <= clr_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (pop) begin
      oword_r  <= oword_nxt;
      okind_r  <= okind_nxt;
      ostat_r  <= ostat_nxt;
      ocrep_r  <= ocrep_nxt;
      oidrep_r <= oidrep_nxt;
    end
  end

  // running_crc is the live CRC register: it changes only on pop
  assign out_tvalid   = ovld_r;
  assign out_tdata    = {3'd0, crc_r, oidrep_r, ocrep_r, ostat_r, oword_r};
  assign out_tuser    = okind_r;
  assign stat.pop     = pop;
  assign stat.stopped = (phase_r == PH_ERROR);

endmodule

[rtl/core/config_packet_crc_fixer_unit.sv]
// Configuration packet CRC fixer: an accepted input word is written into the queue,
// then loads the output register once that register is free or draining. Throughput
// one word per clock unless out_tready stalls; the 37-bit CRC32C network is combinational.
// Synchronous active-low reset clears parser phase, CRC, packet state, queue, output
// valid and both configuration registers. Depends on cpcf_pkg and the macros header.
`timescale 1ns / 1ps
`include "config_packet_crc_fixer_unit_macros.svh"

module config_packet_crc_fixer_unit import cpcf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [31:0]            in_tdata,    // [31:0] in_word
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] out_word, [34:32] status, [35] crc_replaced, [36] idcode_replaced,
  // [68:37] running_crc, [71:69] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,   // [1:0] word_kind
  // configuration port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic        idc_en_r;
  logic [31:0] idc_val_r;
  logic        cfg_wr;
  logic        push;
  item_t       push_item;
  item_t       head;
  q_stat_t     q_stat;
  back_stat_t  b_stat;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idc_en_r  <= 1'b0;
      idc_val_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        CFG_IDX_ENABLE: idc_en_r  <= cfg_pwdata[0];
        CFG_IDX_IDCODE: idc_val_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_paddr[2])
      CFG_IDX_ENABLE: cfg_prdata = {31'd0, idc_en_r};
      CFG_IDX_IDCODE: cfg_prdata = idc_val_r;
      default:        cfg_prdata = '0;
    endcase
  end

  cpcf_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_stat.full),
    .push      (push),
    .push_item (push_item)
  );

  cpcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (b_stat.pop),
    .head      (head),
    .stat      (q_stat)
  );

  cpcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_stat.valid),
    .head       (head),
    .idc_en     (idc_en_r),
    .idc_val    (idc_val_r),
    .stat       (b_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Queue never overfills and the back end only pops a present entry
  `CPCF_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, q_stat.count <= QCNT_W'(QDEPTH))
  `CPCF_ASSERT_IMP(a_pop_valid, clk, rst_n, b_stat.pop, q_stat.valid)
  // An accepted word is held in the queue on the next cycle
  `CPCF_ASSERT_NXT(a_push_held, clk, rst_n, in_tvalid && in_tready, q_stat.valid)
  // A stream error stops the parser until reset
  `CPCF_ASSERT_NXT(a_err_sticky, clk, rst_n, b_stat.stopped, b_stat.stopped)

endmodule
